// ===== src/ciag_pkg.sv =====
// ----------------------------------------------------------------------------
// ciag_pkg
// Shared types and constants for the cube interleave address generator:
// dimension limits, field widths, layout codes, register map, controller
// state and the command bundle between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ciag_pkg;

    // dimension limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_BANDS  = 512;

    // configuration field widths
    localparam int DIM_W    = 13;   // cube_width, cube_height
    localparam int BDIM_W   = 10;   // band_count
    localparam int LAYOUT_W = 2;

    // walk counter widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int BAND_W = $clog2(MAX_BANDS);

    // element offsets
    localparam int ADDR_W = 33;

    // product widths
    localparam int WH_W  = 2 * DIM_W;           // width * height
    localparam int RW_W  = ROW_W + DIM_W;       // row * width
    localparam int RB_W  = ROW_W + BDIM_W;      // row * bands
    localparam int BIL_W = RB_W + 1 + DIM_W;    // (row * bands + band) * width
    localparam int BIP_W = RW_W + 1 + BDIM_W;   // (row * width + col) * bands
    localparam int BSQ_W = BAND_W + WH_W;       // band * width * height

    // interleave layouts
    localparam logic [LAYOUT_W-1:0] LAYOUT_BSQ = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_BIL = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_BIP = 2'd2;

    // register map (word index)
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BANDS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SRC    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DST    = 3'd4;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ADDR
    } ciag_state_t;

    // configuration bundle
    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [BDIM_W-1:0]   bands;
        logic [LAYOUT_W-1:0] src;
        logic [LAYOUT_W-1:0] dst;
    } ciag_cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // take a step request, advance the walk
        logic mul1;     // first product stage
        logic mul2;     // second product stage
        logic load;     // load the result register
    } ciag_cmd_t;

    // layout code three maps to bsq
    function automatic logic [LAYOUT_W-1:0] norm_layout(input logic [LAYOUT_W-1:0] code);
        logic [LAYOUT_W-1:0] r;
        r = code;
        if (code != LAYOUT_BSQ && code != LAYOUT_BIL && code != LAYOUT_BIP) begin
            r = LAYOUT_BSQ;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/cube_interleave_address_generator_core.sv =====
// ----------------------------------------------------------------------------
// cube_interleave_address_generator_core
// Source and destination element offsets for converting a cube between
// bsq, bil and bip layouts, with an APB register port for the shape.
// ----------------------------------------------------------------------------
// Each step request on the s_ channel yields one transfer on the m_ channel
// holding the read and write element offsets of the next element in
// band, row, column order; m_tlast marks the final element, after which the
// walk wraps, and m_tuser flags a shape with a zero dimension (offsets then
// zero). Setting restart in a request restarts the walk at the first element.
// One request is handled at a time and passes through the accept
// cycle, two registered multiplier stages and address assembly into the
// output register. The next request can be taken in the cycle after the
// result is loaded. Assembly waits while an earlier result is still
// held by m_tready low; once the result is loaded, the next request is taken
// even while that result still waits for m_tready. Registers (byte address):
// 0x00 cube_width, 0x04 cube_height, 0x08 band_count, 0x0C source_layout,
// 0x10 dest_layout (0 bsq, 1 bil, 2 bip). Write them only while idle.
`default_nettype none

module cube_interleave_address_generator_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // request channel
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // [0] restart, [7:1] zero
    // result channel
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [71:0]         m_tdata,    // [32:0] read_address, [65:33] write_address,
                                            // [71:66] zero
    output logic                m_tlast,
    output logic                m_tuser,    // [0] shape_error
    // configuration port
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ciag_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [BDIM_W-1:0]   bands_reg;
    logic [LAYOUT_W-1:0] src_reg, dst_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            bands_reg  <= BDIM_W'(1);
            src_reg    <= LAYOUT_BSQ;
            dst_reg    <= LAYOUT_BSQ;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_BANDS:  bands_reg  <= pwdata[BDIM_W-1:0];
                REG_SRC:    src_reg    <= pwdata[LAYOUT_W-1:0];
                REG_DST:    dst_reg    <= pwdata[LAYOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_BANDS:  prdata = 32'(bands_reg);
            REG_SRC:    prdata = 32'(src_reg);
            REG_DST:    prdata = 32'(dst_reg);
            default:    prdata = '0;
        endcase
    end

    ciag_cfg_t cfg;
    assign cfg = '{width: width_reg, height: height_reg, bands: bands_reg,
                   src: src_reg, dst: dst_reg};

    // controller and datapath
    ciag_cmd_t         cmd;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    ciag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ciag_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg),
        .restart       (s_tdata[0]),
        .read_address  (rd_addr),
        .write_address (wr_addr),
        .last          (m_tlast),
        .shape_error   (m_tuser)
    );

    assign m_tdata = {6'd0, wr_addr, rd_addr};

endmodule

`default_nettype wire

// ===== src/ciag_ctrl.sv =====
// ----------------------------------------------------------------------------
// ciag_ctrl
// Sequencer for one step request: accept, two product stages, address
// assembly into the result register, plus the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ciag_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output ciag_pkg::ciag_cmd_t     cmd
);
    import ciag_pkg::*;

    ciag_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_ADDR;
            ST_ADDR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            ST_ADDR: cmd.load = out_free;
            default: cmd = '0;
        endcase
    end

    // result valid flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // an accepted request always starts the product stages
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL1))
        else $error("accepted request did not start the product stages");

    // product stages run back to back into address assembly
    a_stage_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL2) |=> (state_reg == ST_ADDR))
        else $error("second product stage not followed by address assembly");

    // a new result only appears out of address assembly
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_ADDR))
        else $error("result valid raised outside address assembly");

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !cmd.load)
        else $error("result register loaded while a result was stalled");

endmodule

`default_nettype wire

// ===== src/ciag_dpath.sv =====
// ----------------------------------------------------------------------------
// ciag_dpath
// Walk counters, the two product stages of the layout formulas, address
// selection and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ciag_dpath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ciag_pkg::ciag_cmd_t        cmd,
    input  wire ciag_pkg::ciag_cfg_t        cfg,
    input  wire logic                       restart,
    output logic [ciag_pkg::ADDR_W-1:0]     read_address,
    output logic [ciag_pkg::ADDR_W-1:0]     write_address,
    output logic                            last,
    output logic                            shape_error
);
    import ciag_pkg::*;

    // saturated dimensions and normalized layouts
    logic [DIM_W-1:0]    w_sat, h_sat;
    logic [BDIM_W-1:0]   b_sat;
    logic [LAYOUT_W-1:0] src_lay, dst_lay;

    assign w_sat   = (cfg.width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : cfg.width;
    assign h_sat   = (cfg.height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg.height;
    assign b_sat   = (cfg.bands  > BDIM_W'(MAX_BANDS)) ? BDIM_W'(MAX_BANDS) : cfg.bands;
    assign src_lay = norm_layout(cfg.src);
    assign dst_lay = norm_layout(cfg.dst);

    // walk state
    logic [BAND_W-1:0] band_reg, band_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;

    // working copy of the accepted element
    logic [BAND_W-1:0] wband_reg;
    logic [ROW_W-1:0]  wrow_reg;
    logic [COL_W-1:0]  wcol_reg;
    logic [ADDR_W-1:0] wlin_reg;
    logic              werr_reg, wlast_reg;

    // walk step
    logic [BAND_W-1:0] cur_band;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [ADDR_W-1:0] cur_lin;
    logic              err_now, col_wrap, row_wrap, band_wrap, last_now;

    assign cur_band  = restart ? '0 : band_reg;
    assign cur_row   = restart ? '0 : row_reg;
    assign cur_col   = restart ? '0 : col_reg;
    assign cur_lin   = restart ? '0 : lin_reg;
    assign err_now   = (w_sat == '0) || (h_sat == '0) || (b_sat == '0);
    assign col_wrap  = ({1'b0, cur_col}  + DIM_W'(1))  >= w_sat;
    assign row_wrap  = ({1'b0, cur_row}  + DIM_W'(1))  >= h_sat;
    assign band_wrap = ({1'b0, cur_band} + BDIM_W'(1)) >= b_sat;
    assign last_now  = !err_now && col_wrap && row_wrap && band_wrap;

    always_comb begin
        band_next = cur_band;
        row_next  = cur_row;
        col_next  = cur_col;
        lin_next  = cur_lin;
        if (!err_now) begin
            if (col_wrap) begin
                col_next = '0;
                if (row_wrap) begin
                    row_next  = '0;
                    band_next = band_wrap ? '0 : cur_band + BAND_W'(1);
                end else begin
                    row_next = cur_row + ROW_W'(1);
                end
            end else begin
                col_next = cur_col + COL_W'(1);
            end
            lin_next = last_now ? '0 : cur_lin + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            lin_reg  <= '0;
        end else if (cmd.accept) begin
            band_reg <= band_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            lin_reg  <= lin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            wband_reg <= cur_band;
            wrow_reg  <= cur_row;
            wcol_reg  <= cur_col;
            wlin_reg  <= cur_lin;
            werr_reg  <= err_now;
            wlast_reg <= last_now;
        end
    end

    // first product stage
    logic [WH_W-1:0] wh_reg;
    logic [RW_W-1:0] rw_reg;
    logic [RB_W-1:0] rb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            wh_reg <= WH_W'(w_sat) * WH_W'(h_sat);
            rw_reg <= RW_W'(wrow_reg) * RW_W'(w_sat);
            rb_reg <= RB_W'(wrow_reg) * RB_W'(b_sat);
        end
    end

    // second product stage
    logic [RB_W:0]      rb_sum;
    logic [RW_W:0]      rw_sum;
    logic [BSQ_W-1:0]   bsq_prod;
    logic [BIL_W-1:0]   bil_prod;
    logic [BIP_W-1:0]   bip_prod;
    logic [ADDR_W-1:0]  bsq_reg, bil_reg, bip_reg;

    assign rb_sum   = {1'b0, rb_reg} + (RB_W + 1)'(wband_reg);
    assign rw_sum   = {1'b0, rw_reg} + (RW_W + 1)'(wcol_reg);
    assign bsq_prod = BSQ_W'(wband_reg) * BSQ_W'(wh_reg);
    assign bil_prod = BIL_W'(rb_sum) * BIL_W'(w_sat);
    assign bip_prod = BIP_W'(rw_sum) * BIP_W'(b_sat);

    always_ff @(posedge aclk) begin
        if (cmd.mul2) begin
            bsq_reg <= bsq_prod[ADDR_W-1:0];
            bil_reg <= bil_prod[ADDR_W-1:0];
            bip_reg <= bip_prod[ADDR_W-1:0];
        end
    end

    // address assembly per layout
    logic [ADDR_W-1:0] off_bsq, off_bil, off_bip, rd_addr, wr_addr;

    assign off_bsq = bsq_reg + ADDR_W'(rw_reg) + ADDR_W'(wcol_reg);
    assign off_bil = bil_reg + ADDR_W'(wcol_reg);
    assign off_bip = bip_reg + ADDR_W'(wband_reg);

    function automatic logic [ADDR_W-1:0] pick(input logic [LAYOUT_W-1:0] lay,
                                               input logic [ADDR_W-1:0]   a_bsq,
                                               input logic [ADDR_W-1:0]   a_bil,
                                               input logic [ADDR_W-1:0]   a_bip);
        logic [ADDR_W-1:0] r;
        case (lay)
            LAYOUT_BIL: r = a_bil;
            LAYOUT_BIP: r = a_bip;
            default:    r = a_bsq;
        endcase
        return r;
    endfunction

    always_comb begin
        if (werr_reg) begin
            rd_addr = '0;
            wr_addr = '0;
        end else if (src_lay == dst_lay) begin
            rd_addr = wlin_reg;
            wr_addr = wlin_reg;
        end else begin
            rd_addr = pick(src_lay, off_bsq, off_bil, off_bip);
            wr_addr = pick(dst_lay, off_bsq, off_bil, off_bip);
        end
    end

    // result register
    logic [ADDR_W-1:0] rd_reg, wr_reg;
    logic              last_reg, err_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_reg   <= rd_addr;
            wr_reg   <= wr_addr;
            last_reg <= wlast_reg;
            err_reg  <= werr_reg;
        end
    end

    assign read_address  = rd_reg;
    assign write_address = wr_reg;
    assign last          = last_reg;
    assign shape_error   = err_reg;

endmodule

`default_nettype wire
